// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion helpers for the world matrix block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define ESWM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define ESWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESWM_ASSERT(lbl, clk, rst_n, prop, msg)
`define ESWM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/eswm_pkg.sv
// ----------------------------------------------------------------------------
// eswm_pkg - shared types, constants and helpers
// Arctangent table, CORDIC stage payload and matrix stage payloads.
// ----------------------------------------------------------------------------
package eswm_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int TRIG_STAGES = 14;
  localparam int ANGLE_DROP  = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
  localparam int IDX_W       = 5;

  localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [65:0] HALF_Q30     = 66'sd536870912;

  // CORDIC vector and angle, Q30 / 32 bit turn with headroom
  typedef logic signed [32:0] q30_t;
  // rotation terms after one product, Q30
  typedef logic signed [34:0] prod_t;
  // rotation entries after the sums, Q30
  typedef logic signed [35:0] ent_t;

  typedef struct packed {
    q30_t [2:0]  x;
    q30_t [2:0]  y;
    q30_t [2:0]  z;
    logic [2:0]  flip;
    logic [15:0] kx;
    logic [15:0] ky;
    logic [15:0] kz;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } cord_t;

  typedef struct packed {
    prod_t       sxsy;
    prod_t       sxcy;
    prod_t       cycz;
    prod_t       cxsz;
    prod_t       sycz;
    prod_t       cysz;
    prod_t       cxcz;
    prod_t       sysz;
    prod_t       cxsy;
    prod_t       cxcy;
    q30_t        sz;
    q30_t        cz;
    q30_t        nsx;
    logic [15:0] kx;
    logic [15:0] ky;
    logic [15:0] kz;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } mix1_t;

  typedef struct packed {
    ent_t [8:0]  r;
    logic [15:0] kx;
    logic [15:0] ky;
    logic [15:0] kz;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } mix2_t;

  // arctangent of 2^-i in a 32 bit turn
  function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Q30 x Q30 -> Q30, round half up
  function automatic prod_t mul_q30(input q30_t a, input q30_t b);
    logic signed [65:0] p;
    logic signed [65:0] s;
    p = 66'(a) * 66'(b);
    s = (p + HALF_Q30) >>> 30;
    return s[34:0];
  endfunction

endpackage

// File: src/eswm_cordic_cell.sv
// ----------------------------------------------------------------------------
// eswm_cordic_cell - one CORDIC rotation step for all three angles
// Holds the vectors of one item and hands them on each cycle it loads.
// ----------------------------------------------------------------------------
module eswm_cordic_cell (
  input  logic                          clk,
  input  logic                          load,
  input  logic [eswm_pkg::IDX_W-1:0]    stage_idx,
  input  eswm_pkg::cord_t               cell_in,
  output eswm_pkg::cord_t               cell_out
);

  eswm_pkg::cord_t cell_r;
  eswm_pkg::cord_t cell_nxt;
  eswm_pkg::q30_t  atan_w;

  assign atan_w = eswm_pkg::q30_t'({1'b0, eswm_pkg::atan_turn(stage_idx)});

  // rotate toward zero residual angle
  always_comb begin
    cell_nxt = cell_in;
    for (int a = 0; a < 3; a++) begin
      if (!cell_in.z[a][32]) begin
        cell_nxt.x[a] = $signed(cell_in.x[a]) - ($signed(cell_in.y[a]) >>> stage_idx);
        cell_nxt.y[a] = $signed(cell_in.y[a]) + ($signed(cell_in.x[a]) >>> stage_idx);
        cell_nxt.z[a] = $signed(cell_in.z[a]) - atan_w;
      end else begin
        cell_nxt.x[a] = $signed(cell_in.x[a]) + ($signed(cell_in.y[a]) >>> stage_idx);
        cell_nxt.y[a] = $signed(cell_in.y[a]) - ($signed(cell_in.x[a]) >>> stage_idx);
        cell_nxt.z[a] = $signed(cell_in.z[a]) + atan_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

// File: src/eswm_rot_mix.sv
// ----------------------------------------------------------------------------
// eswm_rot_mix - Y-X-Z rotation composition
// Stage one forms the pairwise products, stage two the triple terms and sums.
// ----------------------------------------------------------------------------
module eswm_rot_mix (
  input  logic             clk,
  input  logic             load1,
  input  logic             load2,
  input  eswm_pkg::cord_t  trig_in,
  output eswm_pkg::mix2_t  mix_out
);

  eswm_pkg::q30_t  s_w [3];
  eswm_pkg::q30_t  c_w [3];
  eswm_pkg::mix1_t m1_r;
  eswm_pkg::mix1_t m1_nxt;
  eswm_pkg::mix2_t m2_r;
  eswm_pkg::mix2_t m2_nxt;
  eswm_pkg::q30_t  sxsy_w;
  eswm_pkg::q30_t  sxcy_w;

  // undo the half-turn fold
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (trig_in.flip[a]) begin
        s_w[a] = -$signed(trig_in.y[a]);
        c_w[a] = -$signed(trig_in.x[a]);
      end else begin
        s_w[a] = trig_in.y[a];
        c_w[a] = trig_in.x[a];
      end
    end
  end

  // pairwise products
  always_comb begin
    m1_nxt.sxsy = eswm_pkg::mul_q30(s_w[0], s_w[1]);
    m1_nxt.sxcy = eswm_pkg::mul_q30(s_w[0], c_w[1]);
    m1_nxt.cycz = eswm_pkg::mul_q30(c_w[1], c_w[2]);
    m1_nxt.cxsz = eswm_pkg::mul_q30(c_w[0], s_w[2]);
    m1_nxt.sycz = eswm_pkg::mul_q30(s_w[1], c_w[2]);
    m1_nxt.cysz = eswm_pkg::mul_q30(c_w[1], s_w[2]);
    m1_nxt.cxcz = eswm_pkg::mul_q30(c_w[0], c_w[2]);
    m1_nxt.sysz = eswm_pkg::mul_q30(s_w[1], s_w[2]);
    m1_nxt.cxsy = eswm_pkg::mul_q30(c_w[0], s_w[1]);
    m1_nxt.cxcy = eswm_pkg::mul_q30(c_w[0], c_w[1]);
    m1_nxt.sz   = s_w[2];
    m1_nxt.cz   = c_w[2];
    m1_nxt.nsx  = -$signed(s_w[0]);
    m1_nxt.kx   = trig_in.kx;
    m1_nxt.ky   = trig_in.ky;
    m1_nxt.kz   = trig_in.kz;
    m1_nxt.px   = trig_in.px;
    m1_nxt.py   = trig_in.py;
    m1_nxt.pz   = trig_in.pz;
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      m1_r <= m1_nxt;
    end
  end

  // triple terms and row sums
  assign sxsy_w = eswm_pkg::q30_t'(m1_r.sxsy);
  assign sxcy_w = eswm_pkg::q30_t'(m1_r.sxcy);

  always_comb begin
    m2_nxt.r[0] = 36'(m1_r.cycz) + 36'(eswm_pkg::mul_q30(sxsy_w, m1_r.sz));
    m2_nxt.r[1] = 36'(m1_r.cxsz);
    m2_nxt.r[2] = 36'(eswm_pkg::mul_q30(sxcy_w, m1_r.sz)) - 36'(m1_r.sycz);
    m2_nxt.r[3] = 36'(eswm_pkg::mul_q30(sxsy_w, m1_r.cz)) - 36'(m1_r.cysz);
    m2_nxt.r[4] = 36'(m1_r.cxcz);
    m2_nxt.r[5] = 36'(m1_r.sysz) + 36'(eswm_pkg::mul_q30(sxcy_w, m1_r.cz));
    m2_nxt.r[6] = 36'(m1_r.cxsy);
    m2_nxt.r[7] = 36'(m1_r.nsx);
    m2_nxt.r[8] = 36'(m1_r.cxcy);
    m2_nxt.kx   = m1_r.kx;
    m2_nxt.ky   = m1_r.ky;
    m2_nxt.kz   = m1_r.kz;
    m2_nxt.px   = m1_r.px;
    m2_nxt.py   = m1_r.py;
    m2_nxt.pz   = m1_r.pz;
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      m2_r <= m2_nxt;
    end
  end

  assign mix_out = m2_r;

endmodule

// File: src/eswm_scale_out.sv
// ----------------------------------------------------------------------------
// eswm_scale_out - row scaling, saturation and output register
// Each entry times its row scale, rounded to Q8.8 and clamped to 16 bits.
// ----------------------------------------------------------------------------
module eswm_scale_out (
  input  logic                   clk,
  input  logic                   load,
  input  eswm_pkg::mix2_t        mix_in,
  output logic signed [15:0]     ent [9],
  output logic signed [31:0]     tx,
  output logic signed [31:0]     ty,
  output logic signed [31:0]     tz
);

  logic signed [15:0] ent_r   [9];
  logic signed [15:0] ent_nxt [9];
  logic signed [31:0] tx_r, ty_r, tz_r;
  logic signed [15:0] k_w     [9];
  logic signed [51:0] prod_w  [9];
  logic signed [51:0] q_w     [9];

  // scale, round half up, clamp
  always_comb begin
    for (int e = 0; e < 9; e++) begin
      k_w[e] = (e < 3) ? $signed(mix_in.kx) : ((e < 6) ? $signed(mix_in.ky)
                                                       : $signed(mix_in.kz));
      prod_w[e] = 52'($signed(mix_in.r[e])) * 52'(k_w[e]);
      q_w[e]    = (prod_w[e] + 52'sd536870912) >>> 30;
      if (q_w[e] > 52'sd32767) begin
        ent_nxt[e] = 16'sh7FFF;
      end else if (q_w[e] < -52'sd32768) begin
        ent_nxt[e] = 16'sh8000;
      end else begin
        ent_nxt[e] = q_w[e][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= ent_nxt;
      tx_r  <= mix_in.px;
      ty_r  <= mix_in.py;
      tz_r  <= mix_in.pz;
    end
  end

  assign ent = ent_r;
  assign tx  = tx_r;
  assign ty  = ty_r;
  assign tz  = tz_r;

endmodule

// File: src/euler_scale_world_matrix.sv
// ----------------------------------------------------------------------------
// euler_scale_world_matrix - Euler angles, scale, position to world matrix
// Stages: CORDIC cells, two mix stages, output.
// Throughput one transfer per cycle while out_stall is low; bubbles are squeezed out under stall.
// Synchronous active-low reset clears all stage valids; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euler_scale_world_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [15:0] in_angle_x,
  input  logic        [15:0] in_angle_y,
  input  logic        [15:0] in_angle_z,
  input  logic signed [15:0] in_scale_x,
  input  logic signed [15:0] in_scale_y,
  input  logic signed [15:0] in_scale_z,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_m11,
  output logic signed [15:0] out_m12,
  output logic signed [15:0] out_m13,
  output logic signed [15:0] out_m21,
  output logic signed [15:0] out_m22,
  output logic signed [15:0] out_m23,
  output logic signed [15:0] out_m31,
  output logic signed [15:0] out_m32,
  output logic signed [15:0] out_m33,
  output logic signed [31:0] out_trans_x,
  output logic signed [31:0] out_trans_y,
  output logic signed [31:0] out_trans_z
);

  localparam int NS = eswm_pkg::TRIG_STAGES + 2;

  logic [NS-1:0]         vld_r;
  logic [NS-1:0]         vld_nxt;
  logic [NS-1:0]         rdy;
  logic                  out_vld_r;
  logic                  out_rdy;
  eswm_pkg::cord_t       cell_in0;
  eswm_pkg::cord_t       cell_q [eswm_pkg::TRIG_STAGES];
  eswm_pkg::mix2_t       mix_w;
  logic signed [15:0]    ent_w [9];
  logic [15:0]           ang_w [3];
  logic [31:0]           turn_w;

  // angle precision cut and fold into [-90, 90) degrees
  assign ang_w[0] = in_angle_x;
  assign ang_w[1] = in_angle_y;
  assign ang_w[2] = in_angle_z;

  always_comb begin
    cell_in0 = '0;
    turn_w   = '0;
    for (int a = 0; a < 3; a++) begin
      turn_w = {ang_w[a] & ~16'((17'd1 << eswm_pkg::ANGLE_DROP) - 17'd1), 16'h0000};
      cell_in0.flip[a] = turn_w[31] ^ turn_w[30];
      cell_in0.z[a]    = {turn_w[30], turn_w[30], turn_w[30:0]};
      cell_in0.x[a]    = eswm_pkg::INV_GAIN_Q30;
      cell_in0.y[a]    = '0;
    end
    cell_in0.kx = in_scale_x;
    cell_in0.ky = in_scale_y;
    cell_in0.kz = in_scale_z;
    cell_in0.px = in_pos_x;
    cell_in0.py = in_pos_y;
    cell_in0.pz = in_pos_z;
  end

  // stage advance: a stage moves when empty or when its successor moves
  assign out_rdy = !out_vld_r || !out_stall;

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || out_rdy;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_rdy ? vld_r[NS-1] : out_vld_r;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = out_vld_r;

  // row of CORDIC cells
  for (genvar g = 0; g < eswm_pkg::TRIG_STAGES; g++) begin : g_cell
    eswm_cordic_cell u_cell (
      .clk       (clk),
      .load      (rdy[g]),
      .stage_idx (eswm_pkg::IDX_W'(g)),
      .cell_in   ((g == 0) ? cell_in0 : cell_q[(g == 0) ? 0 : g - 1]),
      .cell_out  (cell_q[g])
    );
  end

  eswm_rot_mix u_mix (
    .clk     (clk),
    .load1   (rdy[NS-2]),
    .load2   (rdy[NS-1]),
    .trig_in (cell_q[eswm_pkg::TRIG_STAGES-1]),
    .mix_out (mix_w)
  );

  eswm_scale_out u_out (
    .clk    (clk),
    .load   (out_rdy),
    .mix_in (mix_w),
    .ent    (ent_w),
    .tx     (out_trans_x),
    .ty     (out_trans_y),
    .tz     (out_trans_z)
  );

  assign out_m11 = ent_w[0];
  assign out_m12 = ent_w[1];
  assign out_m13 = ent_w[2];
  assign out_m21 = ent_w[3];
  assign out_m22 = ent_w[4];
  assign out_m23 = ent_w[5];
  assign out_m31 = ent_w[6];
  assign out_m32 = ent_w[7];
  assign out_m33 = ent_w[8];

  // input backs up only when every stage is full and the output is blocked
  `ESWM_ASSERT(a_stall_full, clk, rst_n, in_stall |-> (&vld_r && out_valid && out_stall), "input stall without full pipeline")
  // reset empties the pipeline
  `ESWM_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> (!out_valid && vld_r == '0), "pipeline not empty after reset")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - world matrix block regression
// Drives Euler angles, row scales and positions through the valid/stall
// channel, predicts each matrix with a CORDIC model of its own and checks
// every result transfer in order against the queue of predicted matrices.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] ax, ay, az;
    logic signed [15:0] kx, ky, kz;
    logic signed [31:0] px, py, pz;
  } pose_t;

  typedef struct {
    logic signed [15:0] m [9];
    logic signed [31:0] t [3];
  } matrix_t;

  localparam int WATCHDOG = 20000;
  localparam int LATENCY  = 17;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic signed [15:0] in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_m11, out_m12, out_m13, out_m21, out_m22, out_m23;
  logic signed [15:0] out_m31, out_m32, out_m33;
  logic signed [31:0] out_trans_x, out_trans_y, out_trans_z;

  matrix_t expected_matrices [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;   // long stretch with no idling on either side

  euler_scale_world_matrix DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // arctangent of 2^-i in a 32 bit turn
  const longint atan_tab [14] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3};

  // SystemVerilog >>> on longint floors, as required
  function automatic longint q30_product(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic void sin_cos(logic [15:0] ang, output longint s, output longint c);
    longint t, x, y, z, dx, dy;
    bit flip;
    t = longint'(ang) << 16;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (t >= 64'h40000000 && t < 64'hC0000000) begin
      t = (t - 64'h80000000) & 64'hFFFFFFFF;
      flip = 1'b1;
    end
    z = (t >= 64'h80000000) ? t - 64'h100000000 : t;
    for (int i = 0; i < 14; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic signed [15:0] scaled_entry(longint r, longint k);
    longint q;
    q = (r * k + 64'sd536870912) >>> 30;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic matrix_t world_matrix(pose_t p);
    matrix_t mt;
    longint sx, cx, sy, cy, sz, cz, sxsy, sxcy;
    longint r [9];
    sin_cos(p.ax, sx, cx);
    sin_cos(p.ay, sy, cy);
    sin_cos(p.az, sz, cz);
    sxsy = q30_product(sx, sy);
    sxcy = q30_product(sx, cy);
    r[0] = q30_product(cy, cz) + q30_product(sxsy, sz);
    r[1] = q30_product(cx, sz);
    r[2] = -q30_product(sy, cz) + q30_product(sxcy, sz);
    r[3] = -q30_product(cy, sz) + q30_product(sxsy, cz);
    r[4] = q30_product(cx, cz);
    r[5] = q30_product(sy, sz) + q30_product(sxcy, cz);
    r[6] = q30_product(cx, sy);
    r[7] = -sx;
    r[8] = q30_product(cx, cy);
    for (int i = 0; i < 9; i++)
      mt.m[i] = scaled_entry(r[i], (i < 3) ? p.kx : (i < 6) ? p.ky : p.kz);
    mt.t[0] = p.px; mt.t[1] = p.py; mt.t[2] = p.pz;
    return mt;
  endfunction

  // one input transfer, driven on the falling edge; valid drops only while idling
  task automatic send_pose(pose_t p);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_angle_x <= p.ax; in_angle_y <= p.ay; in_angle_z <= p.az;
    in_scale_x <= p.kx; in_scale_y <= p.ky; in_scale_z <= p.kz;
    in_pos_x <= p.px; in_pos_y <= p.py; in_pos_z <= p.pz;
    do @(posedge clk); while (in_stall);
    expected_matrices.push_back(world_matrix(p));
    @(negedge clk);
  endtask

  function automatic pose_t random_pose();
    pose_t p;
    p.ax = 16'($urandom); p.ay = 16'($urandom); p.az = 16'($urandom);
    // mostly sensible scales, sometimes the full range
    if ($urandom_range(3) == 0) begin
      p.kx = 16'($urandom); p.ky = 16'($urandom); p.kz = 16'($urandom);
    end else begin
      p.kx = 16'($urandom_range(1024) - 512);
      p.ky = 16'($urandom_range(1024) - 512);
      p.kz = 16'($urandom_range(1024) - 512);
    end
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    return p;
  endfunction

  task automatic test_angle_extremes();
    pose_t p;
    logic [15:0] angs [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                               16'h3FFF, 16'hBFFF, 16'hFFFF, 16'h0001};
    foreach (angs[i]) begin
      p = '{angs[i], angs[(i+3)%8], angs[(i+5)%8], 16'sh0100, 16'sh0100,
            16'sh0100, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0};
      send_pose(p);
    end
  endtask

  task automatic test_saturation();
    pose_t p;
    logic signed [15:0] ks [4] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    foreach (ks[i]) begin
      p = '{16'h0000, 16'h0000, 16'h0000, ks[i], ks[i], ks[i],
            32'shFFFFFFFF, 32'sh00000001, 32'sh55555555};
      send_pose(p);
      p.ax = 16'h4000; p.ay = 16'hC000; p.az = 16'h8000;
      send_pose(p);
    end
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) send_pose(random_pose());
    in_valid <= 1'b0;
    while (expected_matrices.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_random_poses();
    for (int i = 0; i < 880; i++) begin
      calm = (i >= 300 && i < 450);
      send_pose(random_pose());
    end
    calm = 1'b0;
  endtask

  // result side stall
  always @(negedge clk)
    out_stall <= !calm && ($urandom_range(99) < 32);

  // result checker
  always @(posedge clk) begin
    matrix_t exp_m;
    logic signed [15:0] got [9];
    logic signed [31:0] got_t [3];
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_m11, out_m12, out_m13, out_m21, out_m22, out_m23,
              out_m31, out_m32, out_m33};
      got_t = '{out_trans_x, out_trans_y, out_trans_z};
      if (expected_matrices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        exp_m = expected_matrices.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== exp_m.m[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("entry %0d: expected %0d got %0d", i, exp_m.m[i], got[i]);
          end
        for (int i = 0; i < 3; i++)
          if (got_t[i] !== exp_m.t[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("trans %0d: expected %h got %h", i, exp_m.t[i], got_t[i]);
          end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_angle_extremes();
    test_saturation();
    test_drain_pause();
    test_random_poses();
    in_valid <= 1'b0;
    while (expected_matrices.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
